FILE: design/brfo_pkg.sv
// brfo_pkg: shared types, command codes and helpers for the byte ring fifo
// used by brfo_front, brfo_queue, brfo_back and byte_ring_fifo_overwrite
// no dependencies
`default_nettype none

package brfo_pkg;

    // field widths
    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int FILL_W = 8;
    localparam int SIZE_W = 9;

    // largest ring the size register can describe
    localparam int RING_MAX = 511;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    // register index and reset value
    localparam logic REG_SIZE_IN_USE = 1'b0;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // one classified item on its way from front to back
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [SIZE_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
        logic              success;
        logic              dropped;
        logic [FILL_W-1:0] fill;
    } op_t;

    localparam int OP_W = $bits(op_t);

    // advance a ring pointer, wrapping at the ring size
    function automatic logic [SIZE_W-1:0] ring_inc(
        input logic [SIZE_W-1:0] p,
        input logic [SIZE_W-1:0] sz
    );
        logic [SIZE_W:0] s;
        s = {1'b0, p} + {{SIZE_W{1'b0}}, 1'b1};
        return (s == {1'b0, sz}) ? '0 : s[SIZE_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/brfo_ram.sv
// brfo_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none

module brfo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        // read data holds until the next read
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/brfo_front.sv
// brfo_front: accepts commands, owns the ring pointers, classifies each item
// depends on brfo_pkg
`default_nettype none

module brfo_front
    import brfo_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [BYTE_W-1:0] push_byte,
    input  wire logic [BYTE_W-1:0] peek_offset,
    input  wire logic [SIZE_W-1:0] size_in_use,
    input  wire logic              ptr_clear,
    output op_t                    op,
    output logic                   op_valid,
    input  wire logic              op_ready
);

    localparam logic [SIZE_W-1:0] SIZE_CAP =
        SIZE_W'((DEPTH > RING_MAX) ? RING_MAX : DEPTH);
    localparam logic [SIZE_W-1:0] SIZE_MIN = 9'd2;

    logic [SIZE_W-1:0] rp_reg, rp_next;
    logic [SIZE_W-1:0] wp_reg, wp_next;
    logic [SIZE_W-1:0] eff_size;
    logic [SIZE_W-1:0] len;
    logic [SIZE_W-1:0] len_after;
    logic [SIZE_W:0]   len_wide;
    logic [SIZE_W:0]   peek_sum;
    logic [SIZE_W-1:0] peek_addr;
    logic              full;
    logic              accept;

    assign in_ready = op_ready;
    assign op_valid = in_valid;
    assign accept   = in_valid && op_ready;

    // clamp size into the legal ring range
    always_comb begin
        eff_size = size_in_use;
        if (size_in_use < SIZE_MIN) begin
            eff_size = SIZE_MIN;
        end else if (size_in_use > SIZE_CAP) begin
            eff_size = SIZE_CAP;
        end
    end

    // current length and wrapped peek address
    always_comb begin
        if (wp_reg >= rp_reg) begin
            len_wide = {1'b0, wp_reg} - {1'b0, rp_reg};
        end else begin
            len_wide = {1'b0, wp_reg} + {1'b0, eff_size} - {1'b0, rp_reg};
        end
        len  = len_wide[SIZE_W-1:0];
        full = (len == (eff_size - 9'd1));

        peek_sum = {1'b0, rp_reg} + {2'b00, peek_offset};
        if (peek_sum >= {1'b0, eff_size}) begin
            peek_sum = peek_sum - {1'b0, eff_size};
        end
        peek_addr = peek_sum[SIZE_W-1:0];
    end

    always_comb begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        len_after  = len;
        op.wr_en   = 1'b0;
        op.rd_en   = 1'b0;
        op.addr    = rp_reg;
        op.wdata   = push_byte;
        op.success = 1'b1;
        op.dropped = 1'b0;
        unique case (cmd)
            CMD_PUSH: begin
                op.wr_en   = 1'b1;
                op.addr    = wp_reg;
                op.dropped = full;
                wp_next    = ring_inc(wp_reg, eff_size);
                if (full) begin
                    rp_next = ring_inc(rp_reg, eff_size);
                end else begin
                    len_after = len + 9'd1;
                end
            end
            CMD_POP: begin
                if (len == '0) begin
                    op.success = 1'b0;
                end else begin
                    op.rd_en  = 1'b1;
                    rp_next   = ring_inc(rp_reg, eff_size);
                    len_after = len - 9'd1;
                end
            end
            CMD_PEEK: begin
                if ({1'b0, peek_offset} >= len) begin
                    op.success = 1'b0;
                end else begin
                    op.rd_en = 1'b1;
                    op.addr  = peek_addr;
                end
            end
            CMD_CLEAR: begin
                rp_next   = '0;
                wp_next   = '0;
                len_after = '0;
            end
            default: begin
                rp_next = rp_reg;
            end
        endcase
        op.fill = len_after[FILL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ptr_clear) begin
            rp_reg <= '0;
            wp_reg <= '0;
        end else if (accept) begin
            rp_reg <= rp_next;
            wp_reg <= wp_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/brfo_queue.sv
// brfo_queue: two-entry queue between front and back
// depends on brfo_pkg
`default_nettype none

module brfo_queue
    import brfo_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire op_t  in_op,
    output logic      out_valid,
    input  wire logic out_ready,
    output op_t       out_op
);

    op_t        entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_op    = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

`default_nettype wire

FILE: design/brfo_back.sv
// brfo_back: executes store writes and reads, builds and holds results
// depends on brfo_pkg and brfo_ram
`default_nettype none

module brfo_back
    import brfo_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire op_t          op,
    input  wire logic         op_valid,
    output logic              op_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [BYTE_W-1:0] read_byte,
    output logic              success,
    output logic              dropped_oldest,
    output logic [FILL_W-1:0] fill_count
);

    localparam int AW = $clog2(DEPTH);

    logic              pop;
    logic              out_free;
    logic              b_free;
    logic [BYTE_W-1:0] rdata;

    // stage waiting for ram read data
    logic              b_valid_reg, b_valid_next;
    logic              b_rd_reg;
    logic              b_success_reg;
    logic              b_dropped_reg;
    logic [FILL_W-1:0] b_fill_reg;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_byte_reg;
    logic              m_success_reg;
    logic              m_dropped_reg;
    logic [FILL_W-1:0] m_fill_reg;

    assign out_free = !m_valid_reg || out_ready;
    assign b_free   = !b_valid_reg || out_free;
    assign op_ready = b_free;
    assign pop      = op_valid && b_free;

    brfo_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (pop && op.wr_en),
        .re    (pop && op.rd_en),
        .addr  (AW'(op.addr)),
        .wdata (op.wdata),
        .rdata (rdata)
    );

    always_comb begin
        b_valid_next = b_valid_reg;
        if (pop) begin
            b_valid_next = 1'b1;
        end else if (out_free) begin
            b_valid_next = 1'b0;
        end
        m_valid_next = out_free ? b_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            b_rd_reg      <= op.rd_en;
            b_success_reg <= op.success;
            b_dropped_reg <= op.dropped;
            b_fill_reg    <= op.fill;
        end
        if (out_free && b_valid_reg) begin
            m_byte_reg    <= b_rd_reg ? rdata : '0;
            m_success_reg <= b_success_reg;
            m_dropped_reg <= b_dropped_reg;
            m_fill_reg    <= b_fill_reg;
        end
    end

    assign out_valid      = m_valid_reg;
    assign read_byte      = m_byte_reg;
    assign success        = m_success_reg;
    assign dropped_oldest = m_dropped_reg;
    assign fill_count     = m_fill_reg;

endmodule

`default_nettype wire

FILE: design/byte_ring_fifo_overwrite.sv
// byte_ring_fifo_overwrite: byte ring fifo that drops the oldest byte on overflow
// path: queue entry register, then store read stage, then result register
// throughput: one item per cycle unless m_tready stalls; one store port sets it
// reset: synchronous active-low aresetn empties the ring and sets size to 256
// store contents are not cleared; pointer rules never read an unwritten slot
// depends on brfo_pkg, brfo_front, brfo_queue, brfo_back, brfo_ram
`default_nettype none

module byte_ring_fifo_overwrite
    import brfo_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // command stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // cmd[1:0], push_byte[9:2], peek_offset[17:10], zero pad [23:18]
    input  wire logic [S_TDATA_W-1:0] s_tdata,

    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // read_byte[7:0], success[8], dropped_oldest[9], fill_count[17:10],
    // zero pad [23:18]
    output logic [M_TDATA_W-1:0]      m_tdata,

    // configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    // size register, to be written only while the block is idle; not enforced here
    logic [SIZE_W-1:0] size_reg;
    logic              reg_sel;
    logic              cfg_write;

    // front to queue
    op_t  f_op;
    logic f_valid;
    logic f_ready;

    // queue to back
    op_t  q_op;
    logic q_valid;
    logic q_ready;

    // result fields from the back end
    logic [BYTE_W-1:0] r_byte;
    logic              r_success;
    logic              r_dropped;
    logic [FILL_W-1:0] r_fill;

    // register index is the word address; only index zero exists
    assign reg_sel   = (paddr[2] == REG_SIZE_IN_USE);
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;
    assign pready    = 1'b1;
    assign prdata    = reg_sel ? {{(32 - SIZE_W){1'b0}}, size_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else if (cfg_write) begin
            size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // front end: classify command, move pointers, work out length and flags
    brfo_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .cmd         (s_tdata[1:0]),
        .push_byte   (s_tdata[9:2]),
        .peek_offset (s_tdata[17:10]),
        .size_in_use (size_reg),
        .ptr_clear   (cfg_write),
        .op          (f_op),
        .op_valid    (f_valid),
        .op_ready    (f_ready)
    );

    // short queue lets the front keep taking items while the output stalls
    brfo_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_op     (f_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_op    (q_op)
    );

    // back end: store access in order, then the result register
    brfo_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op             (q_op),
        .op_valid       (q_valid),
        .op_ready       (q_ready),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .read_byte      (r_byte),
        .success        (r_success),
        .dropped_oldest (r_dropped),
        .fill_count     (r_fill)
    );

    assign m_tdata = {6'b0, r_fill, r_dropped, r_success, r_byte};

endmodule

`default_nettype wire
